// ===== hdl/message_symbol_unpacker_assert.svh =====
// assertion macros shared by the message symbol unpacker modules
`ifndef MESSAGE_SYMBOL_UNPACKER_ASSERT_SVH
`define MESSAGE_SYMBOL_UNPACKER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MSU_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("msu assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define MSU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("msu assertion failed");

`endif

// ===== hdl/msu_pkg.sv =====
// shared types, codes and character helpers for the message symbol unpacker
`default_nettype none

package msu_pkg;

  localparam int unsigned NSYM            = 12;
  localparam int unsigned MSG_MAX         = 18;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // first call word at or above this value is not a plain call
  localparam logic [27:0] BASE = 28'd262177560;

  // message kinds decided by the front
  localparam logic [2:0] K_TEXT      = 3'd0;
  localparam logic [2:0] K_CALLS     = 3'd1;
  localparam logic [2:0] K_CQ        = 3'd2;
  localparam logic [2:0] K_CQ_NOCALL = 3'd3;
  localparam logic [2:0] K_QRZ       = 3'd4;
  localparam logic [2:0] K_UNKNOWN   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_QRZ     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // decode operations of the back sequencer
  localparam logic [2:0] OP_LIT  = 3'd0;
  localparam logic [2:0] OP_CALL = 3'd1;
  localparam logic [2:0] OP_TEXT = 3'd2;
  localparam logic [2:0] OP_GRID = 3'd3;
  localparam logic [2:0] OP_END  = 3'd4;

  // source word of an operation
  localparam logic [1:0] SRC_W1 = 2'd0;
  localparam logic [1:0] SRC_W2 = 2'd1;
  localparam logic [1:0] SRC_G  = 2'd2;

  // radices of the digit extraction
  localparam logic [7:0] RAD_LETTER = 8'd27;
  localparam logic [7:0] RAD_DIGIT  = 8'd10;
  localparam logic [7:0] RAD_ALNUM  = 8'd36;
  localparam logic [7:0] RAD_TEXT   = 8'd42;
  localparam logic [7:0] RAD_GRID   = 8'd180;

  // call digit that takes the quotient left after five divisions
  localparam logic [2:0] CALL_FINAL_DIG = 3'd5;
  localparam logic [2:0] CALL_DIGITS    = 3'd6;
  localparam logic [2:0] TEXT_LONG      = 3'd5;
  localparam logic [2:0] TEXT_SHORT     = 3'd3;

  // ascii codes
  localparam logic [6:0] CH_NUL   = 7'd0;
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_PLUS  = 7'd43;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_DOT   = 7'd46;
  localparam logic [6:0] CH_SLASH = 7'd47;
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_QMARK = 7'd63;
  localparam logic [6:0] CH_A     = 7'd65;
  localparam logic [6:0] CH_C     = 7'd67;
  localparam logic [6:0] CH_Q     = 7'd81;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] w1;
    logic [27:0] w2;
    logic [16:0] g;
  } desc_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] src;
    logic [4:0] pos;
    logic [2:0] ndig;
    logic [6:0] ch;
  } plan_t;

  function automatic plan_t mk_plan(input logic [2:0] op, input logic [1:0] src,
                                    input logic [4:0] pos, input logic [2:0] ndig,
                                    input logic [6:0] ch);
    plan_t p;
    p.op   = op;
    p.src  = src;
    p.pos  = pos;
    p.ndig = ndig;
    p.ch   = ch;
    return p;
  endfunction

  // operation list of each message kind
  function automatic plan_t plan_of(input logic [2:0] kind, input logic [2:0] idx);
    plan_t p;
    p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
    case (kind)
      K_CALLS: begin
        case (idx)
          3'd0: p = mk_plan(OP_CALL, SRC_W1, 5'd0, CALL_DIGITS, CH_NUL);
          3'd1: p = mk_plan(OP_LIT, SRC_W1, 5'd6, 3'd0, CH_SPACE);
          3'd2: p = mk_plan(OP_CALL, SRC_W2, 5'd7, CALL_DIGITS, CH_NUL);
          3'd3: p = mk_plan(OP_LIT, SRC_W1, 5'd13, 3'd0, CH_SPACE);
          3'd4: p = mk_plan(OP_GRID, SRC_G, 5'd14, 3'd0, CH_NUL);
          default: p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
        endcase
      end
      K_CQ: begin
        case (idx)
          3'd0: p = mk_plan(OP_LIT, SRC_W1, 5'd0, 3'd0, CH_C);
          3'd1: p = mk_plan(OP_LIT, SRC_W1, 5'd1, 3'd0, CH_Q);
          3'd2: p = mk_plan(OP_LIT, SRC_W1, 5'd2, 3'd0, CH_SPACE);
          3'd3: p = mk_plan(OP_CALL, SRC_W2, 5'd3, CALL_DIGITS, CH_NUL);
          3'd4: p = mk_plan(OP_LIT, SRC_W1, 5'd9, 3'd0, CH_SPACE);
          3'd5: p = mk_plan(OP_GRID, SRC_G, 5'd10, 3'd0, CH_NUL);
          default: p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
        endcase
      end
      K_CQ_NOCALL: begin
        case (idx)
          3'd0: p = mk_plan(OP_LIT, SRC_W1, 5'd0, 3'd0, CH_C);
          3'd1: p = mk_plan(OP_LIT, SRC_W1, 5'd1, 3'd0, CH_Q);
          3'd2: p = mk_plan(OP_LIT, SRC_W1, 5'd2, 3'd0, CH_SPACE);
          3'd3: p = mk_plan(OP_LIT, SRC_W1, 5'd3, 3'd0, CH_SPACE);
          3'd4: p = mk_plan(OP_GRID, SRC_G, 5'd4, 3'd0, CH_NUL);
          default: p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
        endcase
      end
      K_TEXT: begin
        case (idx)
          3'd0: p = mk_plan(OP_TEXT, SRC_W1, 5'd0, TEXT_LONG, CH_NUL);
          3'd1: p = mk_plan(OP_TEXT, SRC_W2, 5'd5, TEXT_LONG, CH_NUL);
          3'd2: p = mk_plan(OP_TEXT, SRC_G, 5'd10, TEXT_SHORT, CH_NUL);
          default: p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
        endcase
      end
      default: begin
        case (idx)
          3'd0: p = mk_plan(OP_LIT, SRC_W1, 5'd0, 3'd0, CH_NUL);
          default: p = mk_plan(OP_END, SRC_W1, 5'd0, 3'd0, CH_NUL);
        endcase
      end
    endcase
    return p;
  endfunction

  // character count of each message kind
  function automatic logic [4:0] msg_len(input logic [2:0] kind);
    logic [4:0] n;
    case (kind)
      K_CALLS:     n = 5'd18;
      K_CQ:        n = 5'd14;
      K_CQ_NOCALL: n = 5'd8;
      K_TEXT:      n = 5'd13;
      default:     n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] kind_status(input logic [2:0] kind);
    logic [1:0] s;
    case (kind)
      K_QRZ:     s = ST_QRZ;
      K_UNKNOWN: s = ST_UNKNOWN;
      default:   s = ST_OK;
    endcase
    return s;
  endfunction

  // 42-symbol alphabet: digits, letters, space + - . / ?
  function automatic logic [6:0] alpha(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd10) begin
      c = CH_ZERO + {1'b0, v};
    end else if (v < 6'd36) begin
      c = CH_A + {1'b0, v} - 7'd10;
    end else begin
      case (v)
        6'd36:   c = CH_SPACE;
        6'd37:   c = CH_PLUS;
        6'd38:   c = CH_MINUS;
        6'd39:   c = CH_DOT;
        6'd40:   c = CH_SLASH;
        6'd41:   c = CH_QMARK;
        default: c = CH_NUL;
      endcase
    end
    return c;
  endfunction

  // quotient by ten through a reciprocal, exact below 1029
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] r;
    r = v - (8'(div10(v)) * 8'd10);
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/message_symbol_unpacker.sv =====
// Message symbol unpacker: twelve 6-bit symbols in, one ASCII character per result out.
//
// Input queue: drive symbol and raise push; a symbol is taken on a rising edge
// with push high and full low. Twelve symbols make one message. The first eleven
// are always taken; full rises only on the twelfth while the message queue is full.
// Result queue: while empty is low, char_code, status and last show the oldest
// character; it is taken on a rising edge with pop high. last marks the final
// character. Unsupported QRZ or unknown types give one result, code 0, status 1 or 2.
// A message goes through the message queue (two entries by default) into the decoder,
// which extracts each digit with a reciprocal divide followed by a write.
// Characters then stream out of the buffer at one a cycle while the receiver keeps
// popping them. The front keeps collecting the next message meanwhile.
// Reset (synchronous, rst high) empties the queue and result register and starts
// a fresh message count. A stalled receiver holds the current result and the
// decoder waits; symbols keep being taken until the queue is full.
`default_nettype none

module message_symbol_unpacker
  import msu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [5:0] symbol,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      char_code,
  output logic [1:0]      status,
  output logic            last
);

  desc_t wr_desc;
  desc_t rd_desc;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  // symbol collection and classification
  msu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .symbol (symbol),
    .full   (full),
    .q_push (q_push),
    .q_data (wr_desc),
    .q_full (q_full)
  );

  // message queue
  msu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_desc),
    .empty   (q_empty)
  );

  // decode and character output
  msu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (rd_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== hdl/msu_front.sv =====
// front: gathers twelve symbols, packs the words and classifies the message
`default_nettype none

module msu_front
  import msu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [5:0] symbol,
  output logic            full,
  output logic            q_push,
  output desc_t           q_data,
  input  wire logic       q_full
);

  localparam logic [3:0] LAST_IDX = 4'(NSYM - 1);

  logic [3:0] count;
  logic [5:0] store [NSYM-1];
  logic [5:0] s [NSYM];
  logic [27:0] w1;
  logic [27:0] w2;
  logic [15:0] g;
  logic        accept;

  // only the closing symbol needs room in the queue
  assign full   = (count == LAST_IDX) && q_full;
  assign accept = push && !full;
  assign q_push = accept && (count == LAST_IDX);

  // current message, closing symbol taken straight from the port
  always_comb begin
    for (int i = 0; i < NSYM - 1; i++) begin
      s[i] = store[i];
    end
    s[NSYM-1] = symbol;
    w1 = {s[0], s[1], s[2], s[3], s[4][5:2]};
    w2 = {s[4][1:0], s[5], s[6], s[7], s[8], s[9][5:4]};
    g  = {s[9][3:0], s[10], s[11]};
  end

  // classify and build the queue item
  always_comb begin
    q_data.w1 = w1;
    q_data.w2 = w2;
    q_data.g  = {1'b0, g};
    if (g[15]) begin
      q_data.kind = K_TEXT;
      q_data.w1   = {1'b0, w1[27:1]};
      q_data.w2   = {1'b0, w2[27:1]};
      q_data.g    = {w2[0], w1[0], g[14:0]};
    end else if (w1 < BASE) begin
      q_data.kind = K_CALLS;
    end else if (w1 == BASE + 28'd1) begin
      q_data.kind = (w2 < BASE) ? K_CQ : K_CQ_NOCALL;
    end else if (w1 == BASE + 28'd2) begin
      q_data.kind = K_QRZ;
    end else begin
      q_data.kind = K_UNKNOWN;
    end
  end

  // symbol counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
    end else if (accept) begin
      count <= (count == LAST_IDX) ? 4'd0 : count + 4'd1;
    end
  end

  // symbol store
  always_ff @(posedge clk) begin
    if (accept && (count != LAST_IDX)) begin
      store[count] <= symbol;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msu_queue.sv =====
// short queue of classified messages between front and back
`default_nettype none

module msu_queue
  import msu_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire desc_t wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output desc_t      rd_data,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msu_back.sv =====
// back: digit extraction sequencer, character buffer and result register
`default_nettype none

module msu_back
  import msu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire desc_t      q_data,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      char_code,
  output logic [1:0]      status,
  output logic            last
);

  localparam logic [1:0]  DIV_LAST  = 2'd1;

  // reciprocals and shifts, exact for every dividend below 2^28
  localparam logic [28:0] RCP_LETTER = 29'd318145726;
  localparam logic [5:0]  SH_LETTER  = 6'd33;
  localparam logic [28:0] RCP_DIGIT  = 29'd429496730;
  localparam logic [5:0]  SH_DIGIT   = 6'd32;
  localparam logic [28:0] RCP_ALNUM  = 29'd477218589;
  localparam logic [5:0]  SH_ALNUM   = 6'd34;
  localparam logic [28:0] RCP_TEXT   = 29'd409044505;
  localparam logic [5:0]  SH_TEXT    = 6'd34;
  localparam logic [28:0] RCP_GRID   = 29'd381774871;
  localparam logic [5:0]  SH_GRID    = 6'd36;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PLAN = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_PUT  = 3'd3;
  localparam logic [2:0] B_GRID = 3'd4;
  localparam logic [2:0] B_EMIT = 3'd5;

  logic [2:0]  state;
  desc_t       cur;
  logic [4:0]  len;
  logic [2:0]  op_idx;
  logic [2:0]  cur_op;
  logic [4:0]  cur_pos;
  logic [2:0]  cur_ndig;
  logic [27:0] n;
  logic [27:0] quot;
  logic [7:0]  rem;
  logic [1:0]  div_cnt;
  logic [2:0]  dig;
  logic [6:0]  msg_buf [MSG_MAX];
  logic [4:0]  emit_ptr;
  logic        out_valid;
  logic [6:0]  out_char;
  logic [1:0]  out_status;
  logic        out_last;

  plan_t       step;
  logic [27:0] src_val;
  logic [7:0]  divisor;
  logic [28:0] recip;
  logic [5:0]  rshift;
  logic [56:0] prod;
  logic [15:0] qd;
  logic [27:0] div_q;
  logic [7:0]  div_r;
  logic [6:0]  put_char;
  logic [4:0]  put_pos;
  logic [7:0]  grid_m;
  logic [6:0]  grid_char;
  logic        buf_we;
  logic [4:0]  buf_waddr;
  logic [6:0]  buf_wdata;
  logic        emit_load;
  logic        emit_last;

  assign step  = plan_of(cur.kind, op_idx);
  assign q_pop = (state == B_IDLE) && !q_empty;

  // source word of the planned operation
  always_comb begin
    case (step.src)
      SRC_W1:  src_val = cur.w1;
      SRC_W2:  src_val = cur.w2;
      default: src_val = {11'd0, cur.g};
    endcase
  end

  // radix of the digit in progress, with its reciprocal
  always_comb begin
    case (cur_op)
      OP_CALL: begin
        if (dig < 3'd3) begin
          divisor = RAD_LETTER;
          recip   = RCP_LETTER;
          rshift  = SH_LETTER;
        end else if (dig == 3'd3) begin
          divisor = RAD_DIGIT;
          recip   = RCP_DIGIT;
          rshift  = SH_DIGIT;
        end else begin
          divisor = RAD_ALNUM;
          recip   = RCP_ALNUM;
          rshift  = SH_ALNUM;
        end
      end
      OP_TEXT: begin
        divisor = RAD_TEXT;
        recip   = RCP_TEXT;
        rshift  = SH_TEXT;
      end
      default: begin
        divisor = RAD_GRID;
        recip   = RCP_GRID;
        rshift  = SH_GRID;
      end
    endcase
  end

  // quotient by reciprocal multiply, remainder from the low byte of n - q*d
  always_comb begin
    prod  = {29'd0, n} * {28'd0, recip};
    div_q = 28'(prod >> rshift);
    qd    = {8'd0, quot[7:0]} * {8'd0, divisor};
    div_r = n[7:0] - qd[7:0];
  end

  // character of one extracted digit, written from the right end
  always_comb begin
    if (cur_op == OP_CALL) begin
      if (dig < 3'd3) begin
        put_char = alpha(6'd10 + rem[5:0]);
      end else if (dig == CALL_FINAL_DIG) begin
        put_char = alpha(n[5:0]);
      end else begin
        put_char = alpha(rem[5:0]);
      end
    end else begin
      put_char = alpha(rem[5:0]);
    end
    put_pos = cur_pos + {2'b0, cur_ndig} - 5'd1 - {2'b0, dig};
  end

  // grid square: n holds the quotient by 180, rem the latitude index
  always_comb begin
    if (n[7:0] < 8'd180) begin
      grid_m = 8'd179 - n[7:0];
    end else begin
      grid_m = 8'(9'd359 - {1'b0, n[7:0]});
    end
    case (dig[1:0])
      2'd0:    grid_char = CH_A + {2'b0, div10(grid_m)};
      2'd1:    grid_char = CH_A + {2'b0, div10(rem)};
      2'd2:    grid_char = CH_ZERO + {3'b0, mod10(grid_m)};
      default: grid_char = CH_ZERO + {3'b0, mod10(rem)};
    endcase
  end

  // character buffer write port
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = put_pos;
    buf_wdata = put_char;
    case (state)
      B_PLAN: begin
        buf_we    = (step.op == OP_LIT);
        buf_waddr = step.pos;
        buf_wdata = step.ch;
      end
      B_PUT: begin
        buf_we = 1'b1;
      end
      B_GRID: begin
        buf_we    = 1'b1;
        buf_waddr = cur_pos + {2'b0, dig};
        buf_wdata = grid_char;
      end
      default: buf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      msg_buf[buf_waddr] <= buf_wdata;
    end
  end

  // streaming out of the buffer into the result register
  assign emit_load = (state == B_EMIT) && (!out_valid || pop);
  assign emit_last = (emit_ptr == len - 5'd1);

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_char   <= msg_buf[emit_ptr];
      out_status <= kind_status(cur.kind);
      out_last   <= emit_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur    <= q_data;
            len    <= msg_len(q_data.kind);
            op_idx <= 3'd0;
            state  <= B_PLAN;
          end
        end
        B_PLAN: begin
          cur_op   <= step.op;
          cur_pos  <= step.pos;
          cur_ndig <= step.ndig;
          dig      <= 3'd0;
          rem      <= 8'd0;
          div_cnt  <= 2'd0;
          n        <= src_val;
          case (step.op)
            OP_LIT:  op_idx <= op_idx + 3'd1;
            OP_END: begin
              emit_ptr <= 5'd0;
              state    <= B_EMIT;
            end
            default: state <= B_DIV;
          endcase
        end
        B_DIV: begin
          div_cnt <= div_cnt + 2'd1;
          if (div_cnt == DIV_LAST) begin
            n     <= quot;
            rem   <= div_r;
            state <= (cur_op == OP_GRID) ? B_GRID : B_PUT;
          end else begin
            quot <= div_q;
          end
        end
        B_PUT: begin
          if (dig == cur_ndig - 3'd1) begin
            op_idx <= op_idx + 3'd1;
            state  <= B_PLAN;
          end else begin
            dig     <= dig + 3'd1;
            rem     <= 8'd0;
            div_cnt <= 2'd0;
            if ((cur_op == OP_CALL) && (dig + 3'd1 == CALL_FINAL_DIG)) begin
              state <= B_PUT;
            end else begin
              state <= B_DIV;
            end
          end
        end
        B_GRID: begin
          dig <= dig + 3'd1;
          if (dig == 3'd3) begin
            op_idx <= op_idx + 3'd1;
            state  <= B_PLAN;
          end
        end
        B_EMIT: begin
          if (emit_load) begin
            emit_ptr <= emit_ptr + 5'd1;
            if (emit_last) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign empty      = !out_valid;
  assign char_code  = out_char;
  assign status     = out_status;
  assign last       = out_last;

  // checks on the sequencer
`include "message_symbol_unpacker_assert.svh"

  `MSU_ASSERT_IMPL(a_emit_len, state == B_EMIT, (len != 5'd0) && (len <= 5'(MSG_MAX)))
  `MSU_ASSERT_IMPL(a_write_in_msg, buf_we, buf_waddr < len)
  `MSU_ASSERT_IMPL(a_text_rem, (state == B_PUT) && (cur_op == OP_TEXT), rem < RAD_TEXT)
  `MSU_ASSERT_NEXT(a_end_to_emit, (state == B_PLAN) && (step.op == OP_END),
                   (state == B_EMIT) && (emit_ptr == 5'd0))

endmodule

`default_nettype wire
